@@ src/sfa_pkg.sv @@
// Shared types and constants for the segregated-fit heap allocator.
// Used by the allocator top level; depends on nothing.
package sfa_pkg;

    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int CHUNK_BYTES_DEF = 4096;
    localparam int NUM_CLASSES     = 20;
    localparam int HEADS_END       = 4 * NUM_CLASSES;
    localparam int FIRST_PAYLOAD   = HEADS_END + 16;
    localparam int MIN_BLOCK       = 16;
    localparam int WORD_W          = 32;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] req_bytes;
        logic [15:0] block_offset;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [15:0] payload_offset;
    } out_item_t;

    // Smallest class c whose bound 2^(c+4) holds the size; the top class takes the rest.
    function automatic logic [4:0] size_class(input logic [WORD_W-1:0] size);
        logic [4:0] c;
        c = 5'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
            if (size <= (WORD_W'(1) << (i + 4))) begin
                c = 5'(i);
            end
        end
        return c;
    endfunction

endpackage

@@ src/sfa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module sfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/segregated_fit_heap_allocator.sv @@
// Segregated-fit heap allocator: a sequencer over one word RAM holding the heap.
// Depends on sfa_pkg and sfa_ram.
//
// Usage: items enter on in_valid/in_ready carrying cmd, req_bytes and
// block_offset; one result item leaves on out_valid/out_ready carrying
// status and payload_offset. in_ready is high only while the sequencer is
// idle, so one item is worked on at a time. Every heap access goes through
// the single RAM, one read or one write per cycle, with a registered read.
// The sequencer's steps for each command are:
//   init:  layout writes, then a grow of one chunk with its merge and relink,
//          and loading the result.
//   alloc: class heads read and list blocks visited from the request's class
//          upward, then placing the block, with or without a split (plus a
//          grow and merge on a miss).
//   free:  a walk block by block from the heap start up to the block,
//          then coalescing and relinking.
// A finished result sits in an output register; if the receiver stalls, the
// sequencer waits in its final step until that register is free, and a new
// item is accepted as soon as the result is loaded. Reset clears the break,
// so every command but init fails until init has run; the heap RAM itself
// is not cleared.
module segregated_fit_heap_allocator #(
    parameter int HEAP_BYTES  = sfa_pkg::HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = sfa_pkg::CHUNK_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sfa_pkg::out_item_t out_data
);
    import sfa_pkg::*;

    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = ($clog2(HEAP_BYTES) + 2 > 18) ? $clog2(HEAP_BYTES) + 2 : 18;
    localparam int SW    = AW + 1;

    localparam logic [OW-1:0] HEAP_LIM  = OW'(HEAP_BYTES);
    localparam logic [OW-1:0] CHUNK     = OW'(CHUNK_BYTES);
    localparam logic [OW-1:0] HEADS_O   = OW'(HEADS_END);
    localparam logic [OW-1:0] FIRST_O   = OW'(FIRST_PAYLOAD);
    localparam logic [OW-1:0] MINB_O    = OW'(MIN_BLOCK);
    localparam logic [OW-1:0] ALIGN8    = ~OW'(7);
    localparam logic [OW-1:0] ALIGN4    = ~OW'(3);

    typedef enum logic [5:0] {
        S_IDLE, S_INIT, S_GCHK, S_GM1, S_GM2, S_GEPI,
        S_MSZ, S_MPSZ, S_MRN, S_MNCHK, S_MRP, S_MPCHK, S_MMK1, S_MMK2,
        S_URP, S_URN, S_UW1, S_UW2,
        S_LRD, S_LW1, S_LW2, S_LW3, S_LW4,
        S_FHEAD, S_FHW, S_FP, S_FHDR, S_FNXT,
        S_PRD, S_PW, S_PDEC, S_PS2, S_PS3, S_PS4, S_PF2, S_PUNL,
        S_WHDR, S_WCHK, S_XM1, S_XM2, S_DONE
    } state_t;

    typedef enum logic { GR_INIT, GR_ALLOC } grow_ret_t;
    typedef enum logic { MR_GROW, MR_FREE } merge_ret_t;
    typedef enum logic [1:0] { UR_NEXT, UR_PREV, UR_PLACE } unl_ret_t;
    typedef enum logic { LR_MERGE, LR_PLACE } lnk_ret_t;

    state_t     state_reg;
    grow_ret_t  grow_ret_reg;
    merge_ret_t merge_ret_reg;
    unl_ret_t   unl_ret_reg;
    lnk_ret_t   lnk_ret_reg;

    logic [OW-1:0] brk_reg, off_reg, asz_reg, gbytes_reg, gsz_reg;
    logic [OW-1:0] mbp_reg, msz_reg, psz_reg, total_reg, start_reg;
    logic [OW-1:0] ubp_reg, prev_reg, next_reg;
    logic [OW-1:0] lbp_reg, lsz_reg, slot_reg, old_reg;
    logic [OW-1:0] p_reg, pbp_reg, sz_reg;
    logic [4:0]    cls_reg, idx_reg;
    logic [SW-1:0] steps_reg;
    logic          res_status_reg;
    logic [15:0]   res_pay_reg;
    logic          out_valid_reg;
    out_item_t     out_data_reg;

    logic              mem_we, mem_re;
    logic [OW-1:0]     mem_wb, mem_rb;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic [OW-1:0]     rd_o, rd_size;
    logic [OW-1:0]     gsz_c, req_asz;

    function automatic logic [WORD_W-1:0] ext(input logic [OW-1:0] v);
        return WORD_W'(v);
    endfunction

    sfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_heap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wb[AW+1:2]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_rb[AW+1:2]),
        .rdata (mem_rdata)
    );

    assign rd_o    = mem_rdata[OW-1:0];
    assign rd_size = rd_o & ALIGN8;
    assign gsz_c   = ((gbytes_reg & ALIGN4) + OW'(7)) & ALIGN8;
    assign req_asz = (in_data.req_bytes < 16'd8) ? MINB_O
                   : ((OW'(in_data.req_bytes) + OW'(15)) & ALIGN8);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Memory access issued by the current step.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wb    = '0;
        mem_rb    = '0;
        mem_wdata = '0;
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wb    = OW'({idx_reg, 2'b00});
                mem_wdata = (idx_reg == 5'd21 || idx_reg == 5'd22) ? WORD_W'(9)
                          : (idx_reg == 5'd23) ? WORD_W'(1) : '0;
            end
            S_GM1:  begin mem_we = 1'b1; mem_wb = mbp_reg - OW'(4); mem_wdata = ext(gsz_reg); end
            S_GM2:  begin mem_we = 1'b1; mem_wb = mbp_reg + gsz_reg - OW'(8);
                          mem_wdata = ext(gsz_reg); end
            S_GEPI: begin mem_we = 1'b1; mem_wb = mbp_reg + gsz_reg - OW'(4);
                          mem_wdata = WORD_W'(1); end
            S_MSZ:  begin mem_re = 1'b1; mem_rb = mbp_reg - OW'(4); end
            S_MPSZ: begin mem_re = 1'b1; mem_rb = mbp_reg - OW'(8); end
            S_MRN:  begin mem_re = 1'b1; mem_rb = mbp_reg + msz_reg - OW'(4); end
            S_MRP:  begin mem_re = 1'b1; mem_rb = mbp_reg - psz_reg - OW'(4); end
            S_MMK1: begin mem_we = 1'b1; mem_wb = start_reg - OW'(4); mem_wdata = ext(total_reg); end
            S_MMK2: begin mem_we = 1'b1; mem_wb = start_reg + total_reg - OW'(8);
                          mem_wdata = ext(total_reg); end
            S_URP:  begin mem_re = 1'b1; mem_rb = ubp_reg; end
            S_URN:  begin mem_re = 1'b1; mem_rb = ubp_reg + OW'(4); end
            S_UW1:
            begin
                mem_we    = 1'b1;
                mem_wb    = (prev_reg < HEADS_O) ? prev_reg : prev_reg + OW'(4);
                mem_wdata = mem_rdata;
            end
            S_UW2:  begin mem_we = (next_reg != '0); mem_wb = next_reg; mem_wdata = ext(prev_reg); end
            S_LRD:  begin mem_re = 1'b1; mem_rb = OW'({size_class(ext(lsz_reg)), 2'b00}); end
            S_LW1:  begin mem_we = 1'b1; mem_wb = slot_reg; mem_wdata = ext(lbp_reg); end
            S_LW2:  begin mem_we = 1'b1; mem_wb = lbp_reg; mem_wdata = ext(slot_reg); end
            S_LW3:  begin mem_we = 1'b1; mem_wb = lbp_reg + OW'(4); mem_wdata = ext(old_reg); end
            S_LW4:  begin mem_we = (old_reg != '0); mem_wb = old_reg; mem_wdata = ext(lbp_reg); end
            S_FHEAD: begin mem_re = 1'b1; mem_rb = OW'({cls_reg, 2'b00}); end
            S_FP:   begin mem_re = 1'b1; mem_rb = p_reg - OW'(4); end
            S_FHDR: begin mem_re = 1'b1; mem_rb = p_reg + OW'(4); end
            S_PRD:  begin mem_re = 1'b1; mem_rb = pbp_reg - OW'(4); end
            S_PDEC:
            begin
                mem_we    = 1'b1;
                mem_wb    = pbp_reg - OW'(4);
                mem_wdata = (sz_reg >= asz_reg + MINB_O) ? ext(asz_reg | OW'(1))
                                                         : ext(sz_reg | OW'(1));
            end
            S_PS2:  begin mem_we = 1'b1; mem_wb = pbp_reg + asz_reg - OW'(8);
                          mem_wdata = ext(asz_reg | OW'(1)); end
            S_PS3:  begin mem_we = 1'b1; mem_wb = pbp_reg + asz_reg - OW'(4);
                          mem_wdata = ext(sz_reg - asz_reg); end
            S_PS4:  begin mem_we = 1'b1; mem_wb = pbp_reg + sz_reg - OW'(8);
                          mem_wdata = ext(sz_reg - asz_reg); end
            S_PF2:  begin mem_we = 1'b1; mem_wb = pbp_reg + sz_reg - OW'(8);
                          mem_wdata = ext(sz_reg | OW'(1)); end
            S_WHDR: begin mem_re = 1'b1; mem_rb = p_reg - OW'(4); end
            S_XM1:  begin mem_we = 1'b1; mem_wb = off_reg - OW'(4); mem_wdata = ext(sz_reg); end
            S_XM2:  begin mem_we = 1'b1; mem_wb = off_reg + sz_reg - OW'(8);
                          mem_wdata = ext(sz_reg); end
            default: begin end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            brk_reg        <= '0;
            out_valid_reg  <= 1'b0;
            grow_ret_reg   <= GR_INIT;
            merge_ret_reg  <= MR_GROW;
            unl_ret_reg    <= UR_NEXT;
            lnk_ret_reg    <= LR_MERGE;
        end
        else
        begin
            // The final step reloads the output register itself.
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        off_reg        <= OW'(in_data.block_offset);
                        res_status_reg <= 1'b1;
                        res_pay_reg    <= '0;
                        unique case (cmd_t'(in_data.cmd))
                            CMD_INIT:
                            begin
                                brk_reg   <= '0;
                                idx_reg   <= '0;
                                state_reg <= S_INIT;
                            end
                            CMD_ALLOC:
                            begin
                                if (brk_reg < FIRST_O || in_data.req_bytes == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    asz_reg   <= req_asz;
                                    cls_reg   <= size_class(ext(req_asz));
                                    steps_reg <= '0;
                                    state_reg <= S_FHEAD;
                                end
                            end
                            CMD_FREE:
                            begin
                                if (brk_reg < FIRST_O || OW'(in_data.block_offset) < FIRST_O
                                    || OW'(in_data.block_offset) >= brk_reg
                                    || in_data.block_offset[2:0] != 3'd0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    p_reg     <= FIRST_O;
                                    state_reg <= S_WHDR;
                                end
                            end
                            CMD_NONE: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_INIT:
                begin
                    idx_reg <= idx_reg + 5'd1;
                    if (idx_reg == 5'd23)
                    begin
                        brk_reg      <= FIRST_O;
                        gbytes_reg   <= CHUNK;
                        grow_ret_reg <= GR_INIT;
                        state_reg    <= S_GCHK;
                    end
                end
                S_GCHK:
                begin
                    if (brk_reg + gsz_c > HEAP_LIM)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        mbp_reg   <= brk_reg;
                        gsz_reg   <= gsz_c;
                        brk_reg   <= brk_reg + gsz_c;
                        state_reg <= S_GM1;
                    end
                end
                S_GM1: state_reg <= S_GM2;
                S_GM2: state_reg <= S_GEPI;
                S_GEPI:
                begin
                    merge_ret_reg <= MR_GROW;
                    state_reg     <= S_MSZ;
                end
                S_MSZ:  state_reg <= S_MPSZ;
                S_MPSZ:
                begin
                    msz_reg   <= rd_size;
                    state_reg <= S_MRN;
                end
                S_MRN:
                begin
                    psz_reg   <= rd_size;
                    total_reg <= msz_reg;
                    start_reg <= mbp_reg;
                    state_reg <= S_MNCHK;
                end
                S_MNCHK:
                begin
                    if (!mem_rdata[0])
                    begin
                        total_reg   <= total_reg + rd_size;
                        ubp_reg     <= mbp_reg + msz_reg;
                        unl_ret_reg <= UR_NEXT;
                        state_reg   <= S_URP;
                    end
                    else
                    begin
                        state_reg <= S_MRP;
                    end
                end
                S_MRP: state_reg <= S_MPCHK;
                S_MPCHK:
                begin
                    if (!mem_rdata[0])
                    begin
                        total_reg   <= total_reg + psz_reg;
                        start_reg   <= mbp_reg - psz_reg;
                        ubp_reg     <= mbp_reg - psz_reg;
                        unl_ret_reg <= UR_PREV;
                        state_reg   <= S_URP;
                    end
                    else
                    begin
                        state_reg <= S_MMK1;
                    end
                end
                S_MMK1: state_reg <= S_MMK2;
                S_MMK2:
                begin
                    lbp_reg     <= start_reg;
                    lsz_reg     <= total_reg;
                    lnk_ret_reg <= LR_MERGE;
                    state_reg   <= S_LRD;
                end
                S_URP: state_reg <= S_URN;
                S_URN:
                begin
                    prev_reg  <= rd_o;
                    state_reg <= S_UW1;
                end
                S_UW1:
                begin
                    next_reg  <= rd_o;
                    state_reg <= S_UW2;
                end
                S_UW2:
                begin
                    unique case (unl_ret_reg)
                        UR_NEXT:  state_reg <= S_MRP;
                        UR_PREV:  state_reg <= S_MMK1;
                        UR_PLACE:
                        begin
                            res_status_reg <= 1'b0;
                            res_pay_reg    <= pbp_reg[15:0];
                            state_reg      <= S_DONE;
                        end
                        default:  state_reg <= S_DONE;
                    endcase
                end
                S_LRD:
                begin
                    slot_reg  <= OW'({size_class(ext(lsz_reg)), 2'b00});
                    state_reg <= S_LW1;
                end
                S_LW1:
                begin
                    old_reg   <= rd_o;
                    state_reg <= S_LW2;
                end
                S_LW2: state_reg <= S_LW3;
                S_LW3: state_reg <= S_LW4;
                S_LW4:
                begin
                    if (lnk_ret_reg == LR_PLACE)
                    begin
                        state_reg <= S_PUNL;
                    end
                    else if (merge_ret_reg == MR_FREE)
                    begin
                        res_status_reg <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                    else if (grow_ret_reg == GR_INIT)
                    begin
                        res_status_reg <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        pbp_reg   <= start_reg;
                        state_reg <= S_PRD;
                    end
                end
                S_FHEAD: state_reg <= S_FHW;
                S_FHW:
                begin
                    p_reg     <= rd_o;
                    state_reg <= S_FP;
                end
                S_FP:
                begin
                    // An empty or exhausted list moves the search to the next class, or to a grow after the top class.
                    if (p_reg == '0 || steps_reg >= SW'(DEPTH))
                    begin
                        if (cls_reg == 5'(NUM_CLASSES - 1))
                        begin
                            gbytes_reg   <= (asz_reg > CHUNK) ? asz_reg : CHUNK;
                            grow_ret_reg <= GR_ALLOC;
                            state_reg    <= S_GCHK;
                        end
                        else
                        begin
                            cls_reg   <= cls_reg + 5'd1;
                            state_reg <= S_FHEAD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FHDR;
                    end
                end
                S_FHDR:
                begin
                    if (!mem_rdata[0] && (mem_rdata & ~WORD_W'(7)) >= ext(asz_reg))
                    begin
                        pbp_reg   <= p_reg;
                        state_reg <= S_PRD;
                    end
                    else
                    begin
                        state_reg <= S_FNXT;
                    end
                end
                S_FNXT:
                begin
                    p_reg     <= rd_o;
                    steps_reg <= steps_reg + SW'(1);
                    state_reg <= S_FP;
                end
                S_PRD: state_reg <= S_PW;
                S_PW:
                begin
                    sz_reg    <= rd_size;
                    state_reg <= S_PDEC;
                end
                S_PDEC: state_reg <= (sz_reg >= asz_reg + MINB_O) ? S_PS2 : S_PF2;
                S_PS2:  state_reg <= S_PS3;
                S_PS3:  state_reg <= S_PS4;
                S_PS4:
                begin
                    lbp_reg     <= pbp_reg + asz_reg;
                    lsz_reg     <= sz_reg - asz_reg;
                    lnk_ret_reg <= LR_PLACE;
                    state_reg   <= S_LRD;
                end
                S_PF2: state_reg <= S_PUNL;
                S_PUNL:
                begin
                    ubp_reg     <= pbp_reg;
                    unl_ret_reg <= UR_PLACE;
                    state_reg   <= S_URP;
                end
                S_WHDR:
                begin
                    if (p_reg < brk_reg && p_reg <= off_reg)
                    begin
                        state_reg <= S_WCHK;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_WCHK:
                begin
                    if (rd_size < MINB_O)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (p_reg == off_reg)
                    begin
                        sz_reg    <= rd_size;
                        state_reg <= mem_rdata[0] ? S_XM1 : S_DONE;
                    end
                    else
                    begin
                        p_reg     <= p_reg + rd_size;
                        state_reg <= S_WHDR;
                    end
                end
                S_XM1: state_reg <= S_XM2;
                S_XM2:
                begin
                    mbp_reg       <= off_reg;
                    merge_ret_reg <= MR_FREE;
                    state_reg     <= S_MSZ;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg               <= 1'b1;
                        out_data_reg.status         <= res_status_reg;
                        out_data_reg.payload_offset <= res_pay_reg;
                        state_reg                   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
